@@ hdl/whq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package whq_pkg;

  // Default depth of each sample ring
  localparam int unsigned MaxWindowDefault = 64;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned PctW     = 7;
  localparam int unsigned LenRegW  = 7;
  localparam int unsigned OnesW    = 7;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegOnPercent     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOffPercent    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOnWindowLen   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffWindowLen  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRecentWinLen  = 3'd4;

  // Register reset values
  localparam logic [PctW-1:0]    OnPercentReset    = 7'd70;
  localparam logic [PctW-1:0]    OffPercentReset   = 7'd50;
  localparam logic [LenRegW-1:0] OnWindowLenReset  = 7'd40;
  localparam logic [LenRegW-1:0] OffWindowLenReset = 7'd20;
  localparam logic [LenRegW-1:0] RecentLenReset    = 7'd10;

  // Full scale of a percentage
  localparam logic [PctW-1:0] Pct100 = 7'd100;

  typedef struct packed {
    logic turret_ready;
    logic hood_ready;
    logic wheel_spun_up;
  } in_item_t;

  typedef struct packed {
    logic             qualified;
    logic [OnesW-1:0] on_ones;
  } out_item_t;

  // Clamp a percent register to full scale
  function automatic logic [PctW-1:0] eff_pct(input logic [PctW-1:0] v);
    eff_pct = (v > Pct100) ? Pct100 : v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/whq_window.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One sliding window: bit ring with write position, fill count and ones count.
// The ring is read one slot ahead so the sample that drops out is ready in a
// register when the next push arrives.
module whq_window #(
  parameter int unsigned MaxWindow = whq_pkg::MaxWindowDefault,
  localparam int unsigned PosW = $clog2(MaxWindow),
  localparam int unsigned CntW = $clog2(MaxWindow + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,
  input  wire logic            push_i,
  input  wire logic            sample_i,
  input  wire logic [CntW-1:0] len_i,
  output logic      [CntW-1:0] fill_nxt_o,
  output logic      [CntW-1:0] count_nxt_o
);

  logic [PosW-1:0] pos_q;
  logic [CntW-1:0] fill_q;
  logic [CntW-1:0] count_q;
  logic            rd_q;
  logic            ring_q [MaxWindow];

  logic            full;
  logic [CntW-1:0] pos_inc;
  logic [PosW-1:0] pos_d;
  logic [CntW-1:0] fill_d;
  logic [CntW-1:0] count_d;

  // Window update for one push
  always_comb begin
    full    = (fill_q >= len_i);
    pos_inc = CntW'(pos_q) + CntW'(1);
    pos_d   = (pos_inc == len_i) ? '0 : pos_inc[PosW-1:0];
    fill_d  = full ? fill_q : (fill_q + CntW'(1));
    count_d = count_q + CntW'(sample_i) - CntW'(full & rd_q);
  end

  assign fill_nxt_o  = fill_d;
  assign count_nxt_o = count_d;

  // Control state; a clear empties the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fill_q  <= '0;
      count_q <= '0;
    end else if (clear_i) begin
      pos_q   <= '0;
      fill_q  <= '0;
      count_q <= '0;
    end else if (push_i) begin
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  // Ring storage; slots are only read back once the window is full,
  // so every slot read has been written since the last clear.
  // Bypass covers a window of one slot, where write and next read coincide.
  always_ff @(posedge clk_i) begin
    if (push_i && !clear_i) begin
      ring_q[pos_q] <= sample_i;
      rd_q          <= (pos_d == pos_q) ? sample_i : ring_q[pos_d];
    end
  end

endmodule

`default_nettype wire

@@ hdl/windowed_hysteresis_qualifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   in_data_i  (whq_pkg::in_item_t)
// output    out        out_valid_o / out_stall_i out_data_o (whq_pkg::out_item_t)
// config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while the result is not stalled; an item passes
// the input register, then the window update into the result register.
// Reset leaves the registers at their defaults, all windows empty, flag low.
// A stalled result holds the update stage; the input register still takes one
// more item, then the input stalls too.
module windowed_hysteresis_qualifier #(
  parameter int unsigned MaxWindow = whq_pkg::MaxWindowDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire whq_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output whq_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [whq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [whq_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MaxWindow + 1);
  localparam int unsigned LenW = (CntW > whq_pkg::LenRegW) ? CntW : whq_pkg::LenRegW;
  localparam int unsigned MulW = CntW + whq_pkg::PctW;

  // Clamp a length register to 1..MaxWindow
  function automatic logic [CntW-1:0] eff_len(input logic [whq_pkg::LenRegW-1:0] v);
    logic [LenW-1:0] ext;
    ext = LenW'(v);
    if (v == '0) begin
      eff_len = CntW'(1);
    end else if (ext > LenW'(MaxWindow)) begin
      eff_len = CntW'(MaxWindow);
    end else begin
      eff_len = ext[CntW-1:0];
    end
  endfunction

  // Configuration registers
  logic [whq_pkg::PctW-1:0]    on_pct_q;
  logic [whq_pkg::PctW-1:0]    off_pct_q;
  logic [whq_pkg::LenRegW-1:0] on_len_q;
  logic [whq_pkg::LenRegW-1:0] off_len_q;
  logic [whq_pkg::LenRegW-1:0] rec_len_q;
  logic                        win_clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_pct_q  <= whq_pkg::OnPercentReset;
      off_pct_q <= whq_pkg::OffPercentReset;
      on_len_q  <= whq_pkg::OnWindowLenReset;
      off_len_q <= whq_pkg::OffWindowLenReset;
      rec_len_q <= whq_pkg::RecentLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        whq_pkg::RegOnPercent:    on_pct_q  <= cfg_wdata_i;
        whq_pkg::RegOffPercent:   off_pct_q <= cfg_wdata_i;
        whq_pkg::RegOnWindowLen:  on_len_q  <= cfg_wdata_i;
        whq_pkg::RegOffWindowLen: off_len_q <= cfg_wdata_i;
        whq_pkg::RegRecentWinLen: rec_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Any length write empties all three windows
  assign win_clear = cfg_we_i && ((cfg_idx_i == whq_pkg::RegOnWindowLen) ||
                                  (cfg_idx_i == whq_pkg::RegOffWindowLen) ||
                                  (cfg_idx_i == whq_pkg::RegRecentWinLen));

  // Handshake and pipeline control
  logic s1_valid_q;
  logic s1_sample_q;
  logic out_valid_q;
  logic advance;
  logic in_xfer;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Raw sample: all three subsystems ready
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sample_q <= in_data_i.turret_ready & in_data_i.hood_ready &
                     in_data_i.wheel_spun_up;
    end
  end

  // Effective lengths and percents
  logic [CntW-1:0]          len_on;
  logic [CntW-1:0]          len_off;
  logic [CntW-1:0]          len_rec;
  logic [whq_pkg::PctW-1:0] pon;
  logic [whq_pkg::PctW-1:0] poff;

  assign len_on  = eff_len(on_len_q);
  assign len_off = eff_len(off_len_q);
  assign len_rec = eff_len(rec_len_q);
  assign pon     = whq_pkg::eff_pct(on_pct_q);
  assign poff    = whq_pkg::eff_pct(off_pct_q);

  // The three windows
  logic [CntW-1:0] on_fill_n;
  logic [CntW-1:0] on_cnt_n;
  logic [CntW-1:0] off_fill_n;
  logic [CntW-1:0] off_cnt_n;
  logic [CntW-1:0] rec_fill_n;
  logic [CntW-1:0] rec_cnt_n;

  whq_window #(.MaxWindow(MaxWindow)) u_on_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (win_clear),
    .push_i      (advance),
    .sample_i    (s1_sample_q),
    .len_i       (len_on),
    .fill_nxt_o  (on_fill_n),
    .count_nxt_o (on_cnt_n)
  );

  whq_window #(.MaxWindow(MaxWindow)) u_off_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (win_clear),
    .push_i      (advance),
    .sample_i    (~s1_sample_q),
    .len_i       (len_off),
    .fill_nxt_o  (off_fill_n),
    .count_nxt_o (off_cnt_n)
  );

  whq_window #(.MaxWindow(MaxWindow)) u_rec_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (win_clear),
    .push_i      (advance),
    .sample_i    (~s1_sample_q),
    .len_i       (len_rec),
    .fill_nxt_o  (rec_fill_n),
    .count_nxt_o (rec_cnt_n)
  );

  // Hysteresis: cross-multiplied percent compares on the updated windows
  logic flag_q;
  logic flag_d;
  logic rise_ok;
  logic fall_ok;

  always_comb begin
    rise_ok = (on_fill_n >= len_on) &&
              ((MulW'(on_cnt_n) * MulW'(whq_pkg::Pct100)) >=
               (MulW'(pon) * MulW'(on_fill_n)));
    fall_ok = (off_fill_n >= len_off) && (rec_fill_n >= len_rec) &&
              ((MulW'(off_cnt_n) * MulW'(whq_pkg::Pct100)) >=
               (MulW'(poff) * MulW'(off_fill_n))) &&
              ((MulW'(rec_cnt_n) * MulW'(whq_pkg::Pct100)) >
               (MulW'(poff) * MulW'(rec_fill_n)));
    flag_d  = flag_q ? !fall_ok : rise_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (advance) begin
      flag_q <= flag_d;
    end
  end

  // Result register
  whq_pkg::out_item_t out_data_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.qualified <= flag_d;
      out_data_q.on_ones   <= whq_pkg::OnesW'(on_cnt_n);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ tb/windowed_hysteresis_qualifier_tb.sv @@
`timescale 1ns / 1ps

module windowed_hysteresis_qualifier_tb;

  localparam int unsigned Depth          = whq_pkg::MaxWindowDefault;
  localparam int unsigned RandomItems    = 700;
  localparam int unsigned HoldCycles     = 150;
  localparam int unsigned IdleLimit      = 2000;
  localparam int unsigned SettleCycles   = 4;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Block ports
  logic                         in_valid_i;
  logic                         in_stall_o;
  whq_pkg::in_item_t            in_data_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  whq_pkg::out_item_t           out_data_o;
  logic                         cfg_we_i;
  logic [whq_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [whq_pkg::CfgDataW-1:0] cfg_wdata_i;

  windowed_hysteresis_qualifier DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Sample window: ring of bits, write slot, fill level and count of ones
  typedef struct packed {
    logic [Depth-1:0] slots;
    logic [31:0]      pos;
    logic [31:0]      fill;
    logic [31:0]      ones;
  } sample_window_t;

  // Predicted block state
  logic [whq_pkg::CfgDataW-1:0] reg_on_pct;
  logic [whq_pkg::CfgDataW-1:0] reg_off_pct;
  logic [whq_pkg::CfgDataW-1:0] reg_on_len;
  logic [whq_pkg::CfgDataW-1:0] reg_off_len;
  logic [whq_pkg::CfgDataW-1:0] reg_recent_len;
  sample_window_t               win_on;
  sample_window_t               win_off;
  sample_window_t               win_recent;
  logic                         flag_q;

  whq_pkg::in_item_t  pending_items[$];
  whq_pkg::out_item_t expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned idle_pct       = 15;
  logic        hold_req       = 1'b0;
  int unsigned hold_left      = 0;
  logic        in_xfer        = 1'b0;

  function automatic logic [31:0] clamp_len(logic [whq_pkg::CfgDataW-1:0] v);
    if (v == '0) return 32'd1;
    if (v > Depth) return Depth;
    return 32'(v);
  endfunction

  function automatic logic [31:0] clamp_pct(logic [whq_pkg::CfgDataW-1:0] v);
    return (v > whq_pkg::Pct100) ? 32'(whq_pkg::Pct100) : 32'(v);
  endfunction

  // Push one sample into a window of the given length
  function automatic sample_window_t shift_sample(sample_window_t w, logic [31:0] len,
                                                  logic s);
    logic [31:0] p;
    p = (w.pos >= len) ? 32'd0 : w.pos;
    if (w.fill < len) begin
      w.fill = w.fill + 1;
    end else begin
      w.ones = w.ones - 32'(w.slots[p]);
    end
    w.slots[p] = s;
    w.ones = w.ones + 32'(s);
    p = p + 1;
    w.pos = (p >= len) ? 32'd0 : p;
    return w;
  endfunction

  function automatic void clear_windows();
    win_on     = '0;
    win_off    = '0;
    win_recent = '0;
  endfunction

  function automatic void reset_prediction();
    reg_on_pct     = whq_pkg::OnPercentReset;
    reg_off_pct    = whq_pkg::OffPercentReset;
    reg_on_len     = whq_pkg::OnWindowLenReset;
    reg_off_len    = whq_pkg::OffWindowLenReset;
    reg_recent_len = whq_pkg::RecentLenReset;
    clear_windows();
    flag_q = 1'b0;
  endfunction

  // Any length write empties all windows; the flag survives
  function automatic void apply_reg_write(logic [whq_pkg::CfgIdxW-1:0] idx,
                                          logic [whq_pkg::CfgDataW-1:0] val);
    case (idx)
      whq_pkg::RegOnPercent: begin
        reg_on_pct = val;
      end
      whq_pkg::RegOffPercent: begin
        reg_off_pct = val;
      end
      whq_pkg::RegOnWindowLen: begin
        reg_on_len = val;
        clear_windows();
      end
      whq_pkg::RegOffWindowLen: begin
        reg_off_len = val;
        clear_windows();
      end
      whq_pkg::RegRecentWinLen: begin
        reg_recent_len = val;
        clear_windows();
      end
      default: begin
      end
    endcase
  endfunction

  // One tick of the qualifier: update windows, apply hysteresis, queue the result
  function automatic void qualify_tick(whq_pkg::in_item_t it);
    logic               raw;
    logic [31:0]        lon, loff, lrec, pon, poff;
    whq_pkg::out_item_t res;
    raw  = it.turret_ready & it.hood_ready & it.wheel_spun_up;
    lon  = clamp_len(reg_on_len);
    loff = clamp_len(reg_off_len);
    lrec = clamp_len(reg_recent_len);
    pon  = clamp_pct(reg_on_pct);
    poff = clamp_pct(reg_off_pct);
    win_on     = shift_sample(win_on, lon, raw);
    win_off    = shift_sample(win_off, loff, !raw);
    win_recent = shift_sample(win_recent, lrec, !raw);
    if (!flag_q) begin
      if (win_on.fill >= lon && win_on.ones * 100 >= pon * win_on.fill) flag_q = 1'b1;
    end else if (win_off.fill >= loff && win_recent.fill >= lrec &&
                 win_off.ones * 100 >= poff * win_off.fill &&
                 win_recent.ones * 100 > poff * win_recent.fill) begin
      flag_q = 1'b0;
    end
    res.qualified = flag_q;
    res.on_ones   = whq_pkg::OnesW'(win_on.ones);
    expected_results.push_back(res);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Driver: new transfer offered only when the bus is free or was just taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_xfer)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        in_data_i  <= whq_pkg::in_item_t'(3'($urandom_range(7)));
      end
    end
  end

  // Receiver stall: random, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // Monitor: register writes, result check, input prediction, watchdog
  always @(posedge clk_i) begin
    whq_pkg::out_item_t exp_r;
    logic               any_xfer;
    if (!rst_ni) begin
      in_xfer <= 1'b0;
    end else begin
      any_xfer = cfg_we_i;
      if (cfg_we_i) apply_reg_write(cfg_idx_i, cfg_wdata_i);
      if (out_valid_o && !out_stall_i) begin
        any_xfer = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: qualified=%0b on_ones=%0d",
                                    out_data_o.qualified, out_data_o.on_ones));
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_o.qualified !== exp_r.qualified)
            report_mismatch($sformatf("qualified: got %0b, want %0b",
                                      out_data_o.qualified, exp_r.qualified));
          if (out_data_o.on_ones !== exp_r.on_ones)
            report_mismatch($sformatf("on_ones: got %0d, want %0d",
                                      out_data_o.on_ones, exp_r.on_ones));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        any_xfer = 1'b1;
        qualify_tick(in_data_i);
      end
      in_xfer <= in_valid_i && !in_stall_o;
      if (any_xfer) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
          $display("Timeout: no transfer for %0d cycles", IdleLimit);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Register write, issued from a falling edge
  task automatic write_reg(input logic [whq_pkg::CfgIdxW-1:0] idx,
                           input logic [whq_pkg::CfgDataW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Wait until every item went in and every result came out, then settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [whq_pkg::CfgDataW-1:0] pick_reg_value(
      logic [whq_pkg::CfgIdxW-1:0] idx);
    logic is_pct;
    is_pct = (idx == whq_pkg::RegOnPercent) || (idx == whq_pkg::RegOffPercent);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return is_pct ? whq_pkg::CfgDataW'(100) : whq_pkg::CfgDataW'(Depth);
      3: return is_pct ? whq_pkg::CfgDataW'(101) : whq_pkg::CfgDataW'(Depth + 1);
      4: return is_pct ? whq_pkg::CfgDataW'($urandom_range(127)) :
                         whq_pkg::CfgDataW'($urandom_range(1, 3));
      default: return is_pct ? whq_pkg::CfgDataW'($urandom_range(100)) :
                               whq_pkg::CfgDataW'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic whq_pkg::in_item_t pick_item(int unsigned ready_pct);
    logic [2:0] bits;
    if ($urandom_range(99) < ready_pct) bits = 3'b111;
    else bits = 3'($urandom_range(6));
    return whq_pkg::in_item_t'(bits);
  endfunction

  // Stimulus
  initial begin
    int unsigned                 random_items_sent;
    int unsigned                 phase;
    int unsigned                 n_writes;
    int unsigned                 left;
    int unsigned                 burst;
    int unsigned                 ready_pct;
    logic [31:0]                 longest;
    logic [whq_pkg::CfgIdxW-1:0] idx;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    reset_prediction();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults: every input combination
    for (int v = 0; v < 8; v++) pending_items.push_back(whq_pkg::in_item_t'(3'(v)));
    wait_drained();

    // Zero lengths act as one; oversized percents clamp to full scale
    write_reg(whq_pkg::RegOnWindowLen, '0);
    write_reg(whq_pkg::RegOffWindowLen, '0);
    write_reg(whq_pkg::RegRecentWinLen, '0);
    write_reg(whq_pkg::RegOnPercent, '1);
    write_reg(whq_pkg::RegOffPercent, whq_pkg::CfgDataW'(101));
    pending_items.push_back(whq_pkg::in_item_t'(3'b111));
    pending_items.push_back(whq_pkg::in_item_t'(3'b000));
    pending_items.push_back(whq_pkg::in_item_t'(3'b000));
    wait_drained();

    // Percent write keeps windows; now the recent window can drop the flag
    write_reg(whq_pkg::RegOffPercent, whq_pkg::CfgDataW'(99));
    pending_items.push_back(whq_pkg::in_item_t'(3'b000));
    pending_items.push_back(whq_pkg::in_item_t'(3'b111));
    wait_drained();

    // Unknown indexes are ignored; oversized lengths clamp; flag survives clear
    write_reg(3'd5, '1);
    write_reg(3'd6, '0);
    write_reg(3'd7, '1);
    write_reg(whq_pkg::RegOnWindowLen, '1);
    write_reg(whq_pkg::RegOffWindowLen, whq_pkg::CfgDataW'(Depth + 1));
    write_reg(whq_pkg::RegRecentWinLen, whq_pkg::CfgDataW'(Depth));
    write_reg(whq_pkg::RegOnPercent, '0);
    write_reg(whq_pkg::RegOffPercent, whq_pkg::CfgDataW'(100));
    pending_items.push_back(whq_pkg::in_item_t'(3'b011));
    pending_items.push_back(whq_pkg::in_item_t'(3'b101));
    pending_items.push_back(whq_pkg::in_item_t'(3'b110));
    pending_items.push_back(whq_pkg::in_item_t'(3'b111));
    wait_drained();

    // Short windows: rise, then fall through the off and recent windows
    write_reg(whq_pkg::RegOnWindowLen, whq_pkg::CfgDataW'(3));
    write_reg(whq_pkg::RegOffWindowLen, whq_pkg::CfgDataW'(2));
    write_reg(whq_pkg::RegRecentWinLen, whq_pkg::CfgDataW'(1));
    write_reg(whq_pkg::RegOnPercent, whq_pkg::CfgDataW'(67));
    write_reg(whq_pkg::RegOffPercent, whq_pkg::CfgDataW'(50));
    pending_items.push_back(whq_pkg::in_item_t'(3'b111));
    pending_items.push_back(whq_pkg::in_item_t'(3'b111));
    pending_items.push_back(whq_pkg::in_item_t'(3'b111));
    pending_items.push_back(whq_pkg::in_item_t'(3'b010));
    pending_items.push_back(whq_pkg::in_item_t'(3'b001));
    pending_items.push_back(whq_pkg::in_item_t'(3'b100));
    wait_drained();

    // Random phases: new settings, then bursts of mostly-ready or mostly-not
    random_items_sent = 0;
    phase = 0;
    while (random_items_sent < RandomItems) begin
      n_writes = $urandom_range(1, 4);
      repeat (n_writes) begin
        if ($urandom_range(9) == 0) idx = whq_pkg::CfgIdxW'($urandom_range(5, 7));
        else idx = whq_pkg::CfgIdxW'($urandom_range(4));
        write_reg(idx, pick_reg_value(idx));
      end

      longest = clamp_len(reg_on_len);
      if (clamp_len(reg_off_len) > longest) longest = clamp_len(reg_off_len);
      if (clamp_len(reg_recent_len) > longest) longest = clamp_len(reg_recent_len);
      left = (longest > 16) ? 160 : $urandom_range(30, 90);
      if (left > RandomItems - random_items_sent) left = RandomItems - random_items_sent;

      // One phase without any idling; one with a long receiver hold-off
      idle_pct = (phase == 3) ? 0 : 15;
      if (phase == 2) hold_req = 1'b1;

      while (left > 0) begin
        burst = $urandom_range(3, 20);
        case ($urandom_range(2))
          0: ready_pct = 5;
          1: ready_pct = 50;
          default: ready_pct = 95;
        endcase
        while (burst > 0 && left > 0) begin
          pending_items.push_back(pick_item(ready_pct));
          burst--;
          left--;
          random_items_sent++;
        end
      end
      wait_drained();
      phase++;
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
